>>> hdl/smm_pkg.sv
// Shared types and constants for the sparse row-merge matrix multiplier.
// Holds field widths, mode codes and saturation limits; no dependencies.
package smm_pkg;

    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 48;
    localparam int COUNT_W  = 7;
    localparam int ROW_SLOTS = 64;
    localparam int COL_SLOTS = 64;

    localparam int DEF_INNER_DIM  = 64;
    localparam int DEF_OUT_COLS   = 64;
    localparam int DEF_B_CAPACITY = 1024;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [1:0] MODE_LOAD_B  = 2'd0;
    localparam logic [1:0] MODE_A_ENTRY = 2'd1;
    localparam logic [1:0] MODE_ROW_END = 2'd2;

    localparam logic signed [63:0] PROD_SAT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] PROD_SAT_MIN = -64'sd140737488355328;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

>>> hdl/smm_in_if.sv
// Input channel: valid/ready handshake carrying one B load, A entry or row end.
// Depends on smm_pkg for field widths.
interface smm_in_if import smm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic [ROW_W-1:0]           b_row;
    logic [COL_W-1:0]           column;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, mode, b_row, column, value, input ready);
    modport sink   (input valid, mode, b_row, column, value, output ready);
endinterface

>>> hdl/smm_out_if.sv
// Output channel: valid/ready handshake carrying one nonzero of a result row.
// Depends on smm_pkg for field widths.
interface smm_out_if import smm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [COL_W-1:0]           out_column;
    logic signed [SUM_W-1:0]    out_value;
    logic                       last_of_row;
    logic                       row_empty;
    logic [COUNT_W-1:0]         row_nonzeros;

    modport source (output valid, out_column, out_value, last_of_row, row_empty,
                    row_nonzeros, input ready);
    modport sink   (input valid, out_column, out_value, last_of_row, row_empty,
                    row_nonzeros, output ready);
endinterface

>>> hdl/sparse_matrix_multiply_row_merge.sv
// Row-wise sparse product C = A*B on one shared multiply/accumulate unit (smm_pkg, smm_*_if).
// A kept B load then writes its row count; a dropped load, an out-of-range A entry or an
// unused B row goes back to idle. Each entry of an A entry's B row is read, multiplied, clamped
// and accumulated; a row end counts, then emits its nonzeros or marks an empty row, on output stalls.
// One transaction at a time, ready only when idle. Reset: control, row flags, load count and
// column flags clear at once; B store, row table and accumulator are undefined until written.
module sparse_matrix_multiply_row_merge
    import smm_pkg::*;
#(
    parameter int INNER_DIM  = DEF_INNER_DIM,
    parameter int OUT_COLS   = DEF_OUT_COLS,
    parameter int B_CAPACITY = DEF_B_CAPACITY,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    smm_in_if.sink    item,
    smm_out_if.source result
);

    // Store address and count widths follow the capacity.
    localparam int AW = (B_CAPACITY > 1) ? $clog2(B_CAPACITY) : 1;
    localparam int CW = $clog2(B_CAPACITY + 1);
    localparam int IW = CW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WALK     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_TERM     = 4'd3;
    localparam logic [3:0] S_ADD      = 4'd4;
    localparam logic [3:0] S_CNT_RD   = 4'd5;
    localparam logic [3:0] S_CNT_CHK  = 4'd6;
    localparam logic [3:0] S_EMIT_RD  = 4'd7;
    localparam logic [3:0] S_EMIT_CHK = 4'd8;
    localparam logic [3:0] S_MARK     = 4'd9;
    localparam logic [3:0] S_LOAD     = 4'd10;
    localparam logic [3:0] S_FETCH    = 4'd11;

    // B store: value and column per loaded entry.
    logic signed [VALUE_W-1:0] b_val_mem [B_CAPACITY];
    logic [COL_W-1:0]          b_col_mem [B_CAPACITY];
    // Per-column accumulator; a column whose touched flag is clear reads as zero.
    logic signed [SUM_W-1:0]   acc_mem   [COL_SLOTS];

    // Row table: start and entry count per B row, both read through registers.
    // A row whose used flag is clear has no entries.
    logic [AW-1:0]        b_start_mem [ROW_SLOTS];
    logic [CW-1:0]        b_count_mem [ROW_SLOTS];
    logic [ROW_SLOTS-1:0] row_used_reg;
    logic [CW-1:0]        loaded_reg;

    logic [3:0]                state_reg, state_next;
    logic [COL_SLOTS-1:0]      touched_reg, touched_next;
    logic signed [VALUE_W-1:0] a_val_reg, a_val_next;
    logic [ROW_W-1:0]          row_sel_reg, row_sel_next;
    logic [IW-1:0]             walk_idx_reg, walk_idx_next;
    logic [CW-1:0]             walk_left_reg, walk_left_next;
    logic signed [63:0]        prod_reg, prod_next;
    logic signed [SUM_W-1:0]   term_reg, term_next;
    logic [COL_W-1:0]          scan_reg, scan_next;
    logic [COUNT_W-1:0]        nz_count_reg, nz_count_next;
    logic [COUNT_W-1:0]        emitted_reg, emitted_next;

    logic                      out_valid_reg, out_valid_next;
    logic [COL_W-1:0]          out_col_reg, out_col_next;
    logic signed [SUM_W-1:0]   out_val_reg, out_val_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_empty_reg, out_empty_next;
    logic [COUNT_W-1:0]        out_count_reg, out_count_next;

    // Registered memory read data.
    logic signed [VALUE_W-1:0] b_val_q;
    logic [COL_W-1:0]          b_col_q;
    logic signed [SUM_W-1:0]   acc_q;
    logic [COL_W-1:0]          acc_rd_addr;
    logic [AW-1:0]             row_start_q;
    logic [CW-1:0]             row_count_q;
    logic                      row_used_q;
    logic [ROW_W-1:0]          row_rd_addr;
    logic [CW-1:0]             row_count_eff;
    logic                      count_wr_en;

    logic                      accept;
    logic                      load_ok;
    logic                      b_wr_en;
    logic                      acc_wr_en;
    logic signed [SUM_W-1:0]   acc_wr_data;
    logic signed [63:0]        prod_shift;
    logic signed [SUM_W-1:0]   acc_base;
    logic signed [SUM_W:0]     acc_sum;
    logic                      walk_done;
    logic                      scan_last;
    logic                      scan_hit;
    logic                      out_free;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    // A B entry is kept only while the store has room and its row and column fit.
    assign load_ok = (int'(loaded_reg) < B_CAPACITY) && (int'(item.b_row) < INNER_DIM)
                     && (int'(item.column) < OUT_COLS);
    assign b_wr_en = accept && (item.mode == MODE_LOAD_B) && load_ok;

    // Look the row up at the accept edge; later states hold the latched row.
    assign row_rd_addr   = (state_reg != S_IDLE) ? row_sel_reg
                           : (item.mode == MODE_LOAD_B) ? item.b_row : item.column;
    assign row_count_eff = row_used_q ? row_count_q : '0;
    assign count_wr_en   = (state_reg == S_LOAD);

    assign walk_done = (walk_left_reg == '0) || (int'(walk_idx_reg) >= B_CAPACITY);
    assign scan_last = (int'(scan_reg) == OUT_COLS - 1);
    assign scan_hit  = touched_reg[scan_reg] && (acc_q != '0);
    assign out_free  = !out_valid_reg || result.ready;

    // Scale the registered product back to FRAC_BITS fraction bits (Q32.16 by default), then clamp to 48 bits.
    assign prod_shift = prod_reg >>> FRAC_BITS;

    assign acc_base = touched_reg[b_col_q] ? acc_q : '0;
    assign acc_sum  = (SUM_W+1)'(acc_base) + (SUM_W+1)'(term_reg);

    // Walk states read the accumulator at the B entry's column, row end scans it.
    assign acc_rd_addr = (state_reg == S_MUL || state_reg == S_TERM || state_reg == S_ADD)
                         ? b_col_q : scan_reg;

    always_ff @(posedge clk)
    begin
        if (b_wr_en)
        begin
            b_val_mem[loaded_reg[AW-1:0]] <= item.value;
            b_col_mem[loaded_reg[AW-1:0]] <= item.column;
        end
        b_val_q <= b_val_mem[walk_idx_reg[AW-1:0]];
        b_col_q <= b_col_mem[walk_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (acc_wr_en)
        begin
            acc_mem[b_col_q] <= acc_wr_data;
        end
        acc_q <= acc_mem[acc_rd_addr];
    end

    // Row start is set by the first kept entry of a row at the accept edge; the count
    // is bumped in the next cycle from the value read at that edge.
    always_ff @(posedge clk)
    begin
        if (b_wr_en && !row_used_reg[item.b_row])
        begin
            b_start_mem[item.b_row] <= loaded_reg[AW-1:0];
        end
        if (count_wr_en)
        begin
            b_count_mem[row_sel_reg] <= row_count_eff + CW'(1);
        end
        row_start_q <= b_start_mem[row_rd_addr];
        row_count_q <= b_count_mem[row_rd_addr];
        row_used_q  <= row_used_reg[row_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_used_reg <= '0;
            loaded_reg   <= '0;
        end
        else if (b_wr_en)
        begin
            row_used_reg[item.b_row] <= 1'b1;
            loaded_reg               <= loaded_reg + CW'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        touched_next   = touched_reg;
        a_val_next     = a_val_reg;
        row_sel_next   = row_sel_reg;
        walk_idx_next  = walk_idx_reg;
        walk_left_next = walk_left_reg;
        prod_next      = prod_reg;
        term_next      = term_reg;
        scan_next      = scan_reg;
        nz_count_next  = nz_count_reg;
        emitted_next   = emitted_reg;
        acc_wr_en      = 1'b0;
        acc_wr_data    = acc_sum[SUM_W-1:0];

        // Drop the held result once taken; a new load below overrides.
        out_valid_next = out_valid_reg && !result.ready;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_count_next = out_count_reg;

        // Saturate the accumulator sum when the two top bits disagree.
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1])
        begin
            acc_wr_data = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_LOAD_B:
                        begin
                            // Store entry and row start are written at the accept edge.
                            if (load_ok)
                            begin
                                row_sel_next = item.b_row;
                                state_next   = S_LOAD;
                            end
                        end
                        MODE_A_ENTRY:
                        begin
                            if (int'(item.column) < INNER_DIM)
                            begin
                                a_val_next   = item.value;
                                row_sel_next = item.column;
                                state_next   = S_FETCH;
                            end
                        end
                        MODE_ROW_END:
                        begin
                            scan_next     = '0;
                            nz_count_next = '0;
                            emitted_next  = '0;
                            state_next    = S_CNT_RD;
                        end
                        default:
                        begin
                            // Mode 3 is ignored.
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                // Row count is written this cycle.
                state_next = S_IDLE;
            end
            S_FETCH:
            begin
                // Row start and count are valid now; an unused row adds nothing.
                if (row_used_q)
                begin
                    walk_idx_next  = IW'(row_start_q);
                    walk_left_next = row_count_q;
                    state_next     = S_WALK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                // B store read of walk_idx is issued this cycle.
                state_next = walk_done ? S_IDLE : S_MUL;
            end
            S_MUL:
            begin
                prod_next  = 64'(a_val_reg) * 64'(b_val_q);
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (prod_shift > PROD_SAT_MAX)
                begin
                    term_next = SUM_MAX;
                end
                else if (prod_shift < PROD_SAT_MIN)
                begin
                    term_next = SUM_MIN;
                end
                else
                begin
                    term_next = prod_shift[SUM_W-1:0];
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_wr_en             = 1'b1;
                touched_next[b_col_q] = 1'b1;
                walk_idx_next         = walk_idx_reg + IW'(1);
                walk_left_next        = walk_left_reg - CW'(1);
                state_next            = S_WALK;
            end
            S_CNT_RD:
            begin
                state_next = S_CNT_CHK;
            end
            S_CNT_CHK:
            begin
                if (scan_hit)
                begin
                    nz_count_next = nz_count_reg + COUNT_W'(1);
                end
                if (scan_last)
                begin
                    scan_next  = '0;
                    state_next = ((nz_count_reg == '0) && !scan_hit) ? S_MARK : S_EMIT_RD;
                end
                else
                begin
                    scan_next  = scan_reg + COL_W'(1);
                    state_next = S_CNT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_CHK;
            end
            S_EMIT_CHK:
            begin
                // Hold on a nonzero column until the output register frees up.
                if (!scan_hit || out_free)
                begin
                    if (scan_hit)
                    begin
                        out_valid_next = 1'b1;
                        out_col_next   = scan_reg;
                        out_val_next   = acc_q;
                        out_last_next  = ((emitted_reg + COUNT_W'(1)) == nz_count_reg);
                        out_empty_next = 1'b0;
                        out_count_next = nz_count_reg;
                        emitted_next   = emitted_reg + COUNT_W'(1);
                    end
                    if (scan_last)
                    begin
                        touched_next = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + COL_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_MARK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = '0;
                    out_val_next   = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    out_count_next = '0;
                    touched_next   = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            touched_reg   <= '0;
            out_valid_reg <= 1'b0;
            walk_left_reg <= '0;
            nz_count_reg  <= '0;
            emitted_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            touched_reg   <= touched_next;
            out_valid_reg <= out_valid_next;
            walk_left_reg <= walk_left_next;
            nz_count_reg  <= nz_count_next;
            emitted_reg   <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_val_reg     <= a_val_next;
        row_sel_reg   <= row_sel_next;
        walk_idx_reg  <= walk_idx_next;
        prod_reg      <= prod_next;
        term_reg      <= term_next;
        scan_reg      <= scan_next;
        out_col_reg   <= out_col_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_count_reg <= out_count_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.out_column   = out_col_reg;
    assign result.out_value    = out_val_reg;
    assign result.last_of_row  = out_last_reg;
    assign result.row_empty    = out_empty_reg;
    assign result.row_nonzeros = out_count_reg;

endmodule
